// File: hdl/sab_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sab_pkg
// Shared widths, register indexes, color coefficients and sample types for
// the subtitle alpha blend core.
// ----------------------------------------------------------------------------
package sab_pkg;

    localparam int unsigned COORD_W    = 13;
    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned SIZE_W     = 14;
    localparam int unsigned SHIFT_W    = 2;
    localparam int unsigned COLOR_W    = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned PROD_W     = 2 * SAMPLE_W;
    localparam int unsigned CONV_W     = 18;

    // Sample lanes inside a yuv_t
    localparam int unsigned CH_Y = 0;
    localparam int unsigned CH_U = 1;
    localparam int unsigned CH_V = 2;
    localparam int unsigned NUM_CH = 3;

    typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] yuv_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_OVERLAY_COLOR  = 3'd0,
        REG_FRAME_WIDTH    = 3'd1,
        REG_FRAME_HEIGHT   = 3'd2,
        REG_CHROMA_SHIFT_X = 3'd3,
        REG_CHROMA_SHIFT_Y = 3'd4
    } cfg_reg_t;

    // RGB to YUV coefficients (scaled by 1024)
    localparam logic [CONV_W-1:0] K_Y_R = 18'd263;
    localparam logic [CONV_W-1:0] K_Y_G = 18'd516;
    localparam logic [CONV_W-1:0] K_Y_B = 18'd100;
    localparam logic [CONV_W-1:0] K_U_R = 18'd152;
    localparam logic [CONV_W-1:0] K_U_G = 18'd298;
    localparam logic [CONV_W-1:0] K_UV_P = 18'd450;
    localparam logic [CONV_W-1:0] K_V_G = 18'd376;
    localparam logic [CONV_W-1:0] K_V_B = 18'd73;
    localparam logic [SAMPLE_W-1:0] Y_OFFSET = 8'd16;
    // 128 << 10: keeps the chroma sums nonnegative, floor shift then adds 128
    localparam logic [CONV_W-1:0] UV_BIAS = 18'd131072;

endpackage
`default_nettype wire

// File: hdl/subtitle_alpha_blend_yuv_core.sv
`default_nettype none
// Three register stages (color and weight, channel products, sum and select) lie
// between an input transfer and its result on the m_ side; one pixel per clock
// while m_tready allows it, and each stage stalls only when full and blocked.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: opaque black color, 1920x1080 frame, 4:2:0 shifts.
// ----------------------------------------------------------------------------
// subtitle_alpha_blend_yuv_core
// Blends a subtitle coverage sample of a configured overlay color into a YUV
// pixel, with frame clipping and chroma coordinate output.
// ----------------------------------------------------------------------------
module subtitle_alpha_blend_yuv_core
    import sab_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pixel_x[12:0], pixel_y[25:13], coverage[33:26], luma_in[41:34],
    // cb_in[49:42], cr_in[57:50], zero fill
    input  wire logic [63:0]           s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // luma_out[7:0], cb_out[15:8], cr_out[23:16], chroma_x[36:24],
    // chroma_y[49:37], zero fill
    output logic [55:0]                m_tdata,
    // written[0]
    output logic [0:0]                 m_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [COLOR_W-1:0]    cfg_wdata
);

    // configuration
    logic [COLOR_W-1:0] color_reg;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SHIFT_W-1:0] shift_x_reg;
    logic [SHIFT_W-1:0] shift_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg   <= '0;
            width_reg   <= 14'd1920;
            height_reg  <= 14'd1080;
            shift_x_reg <= 2'd1;
            shift_y_reg <= 2'd1;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_OVERLAY_COLOR:  color_reg   <= cfg_wdata;
                REG_FRAME_WIDTH:    width_reg   <= cfg_wdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT:   height_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_CHROMA_SHIFT_X: shift_x_reg <= cfg_wdata[SHIFT_W-1:0];
                REG_CHROMA_SHIFT_Y: shift_y_reg <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    assign en3      = !v3_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: clip test, coordinates, weight, overlay color
    logic [COORD_W-1:0]  px, py;
    logic [SAMPLE_W-1:0] cov;
    yuv_t                old_next;
    yuv_t                col_next;
    logic                inside_next;
    logic [PROD_W-1:0]   k_prod;
    logic [SAMPLE_W-1:0] k_next;
    logic [COORD_W-1:0]  cx_next, cy_next;

    assign px            = s_tdata[12:0];
    assign py            = s_tdata[25:13];
    assign cov           = s_tdata[33:26];
    assign old_next[CH_Y] = s_tdata[41:34];
    assign old_next[CH_U] = s_tdata[49:42];
    assign old_next[CH_V] = s_tdata[57:50];

    assign inside_next = ({1'b0, px} < width_reg) && ({1'b0, py} < height_reg);
    assign cx_next     = px >> shift_x_reg;
    assign cy_next     = py >> shift_y_reg;
    assign k_prod      = PROD_W'(cov) * PROD_W'(8'd255 - color_reg[7:0]);
    assign k_next      = k_prod[15:8];

    sab_rgb2yuv u_rgb2yuv (
        .color (color_reg),
        .yuv   (col_next)
    );

    logic                inside1_reg;
    logic [COORD_W-1:0]  cx1_reg, cy1_reg;
    logic [SAMPLE_W-1:0] k1_reg;
    yuv_t                col1_reg;
    yuv_t                old1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
        if (en1 && s_tvalid) begin
            inside1_reg <= inside_next;
            cx1_reg     <= cx_next;
            cy1_reg     <= cy_next;
            k1_reg      <= k_next;
            col1_reg    <= col_next;
            old1_reg    <= old_next;
        end
    end

    // stage 2: weighted products per channel
    logic [SAMPLE_W-1:0]           k_inv;
    logic [NUM_CH-1:0][PROD_W-1:0] pc_next, po_next;

    assign k_inv = 8'd255 - k1_reg;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            pc_next[ch] = PROD_W'(k1_reg) * PROD_W'(col1_reg[ch]);
            po_next[ch] = PROD_W'(k_inv) * PROD_W'(old1_reg[ch]);
        end
    end

    logic                          inside2_reg;
    logic [COORD_W-1:0]            cx2_reg, cy2_reg;
    yuv_t                          old2_reg;
    logic [NUM_CH-1:0][PROD_W-1:0] pc2_reg, po2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2 && v1_reg) begin
            inside2_reg <= inside1_reg;
            cx2_reg     <= cx1_reg;
            cy2_reg     <= cy1_reg;
            old2_reg    <= old1_reg;
            pc2_reg     <= pc_next;
            po2_reg     <= po_next;
        end
    end

    // stage 3: sum, scale, pass clipped pixels through
    logic [PROD_W:0] mix_sum [NUM_CH];
    yuv_t            out_next;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            mix_sum[ch]  = (PROD_W + 1)'(pc2_reg[ch]) + (PROD_W + 1)'(po2_reg[ch]);
            out_next[ch] = inside2_reg ? mix_sum[ch][15:8] : old2_reg[ch];
        end
    end

    logic               written3_reg;
    logic [COORD_W-1:0] cx3_reg, cy3_reg;
    yuv_t               out3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
        if (en3 && v2_reg) begin
            written3_reg <= inside2_reg;
            cx3_reg      <= cx2_reg;
            cy3_reg      <= cy2_reg;
            out3_reg     <= out_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = {6'd0, cy3_reg, cx3_reg, out3_reg[CH_V], out3_reg[CH_U], out3_reg[CH_Y]};
    assign m_tuser  = written3_reg;

`ifndef NO_ASSERTIONS
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && !en2 |=> v1_reg && $stable(k1_reg) && $stable(old1_reg))
        else $error("stage 1 item lost during stall");

    a_s2_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !en3 |=> v2_reg && $stable(pc2_reg) && $stable(old2_reg))
        else $error("stage 2 item lost during stall");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && v3_reg && !m_tready |-> !s_tready)
        else $error("input accepted into a full stalled pipeline");

    a_clip_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && en3 && !inside2_reg |=> out3_reg == $past(old2_reg) && !written3_reg)
        else $error("clipped pixel altered");
`endif

endmodule
`default_nettype wire

// File: hdl/sab_rgb2yuv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sab_rgb2yuv
// Converts the RGBA overlay color into Y, U and V samples with the integer
// coefficient set; alpha is ignored here.
// ----------------------------------------------------------------------------
module sab_rgb2yuv
    import sab_pkg::*;
(
    input  wire logic [COLOR_W-1:0] color,
    output yuv_t                    yuv
);

    logic [CONV_W-1:0] r;
    logic [CONV_W-1:0] g;
    logic [CONV_W-1:0] b;
    logic [CONV_W-1:0] y_sum;
    logic [CONV_W-1:0] u_sum;
    logic [CONV_W-1:0] v_sum;

    assign r = CONV_W'(color[31:24]);
    assign g = CONV_W'(color[23:16]);
    assign b = CONV_W'(color[15:8]);

    // Chroma sums stay nonnegative thanks to the bias, so modular math is exact
    assign y_sum = K_Y_R * r + K_Y_G * g + K_Y_B * b;
    assign u_sum = UV_BIAS + K_UV_P * b - K_U_R * r - K_U_G * g;
    assign v_sum = UV_BIAS + K_UV_P * r - K_V_G * g - K_V_B * b;

    assign yuv[CH_Y] = y_sum[17:10] + Y_OFFSET;
    assign yuv[CH_U] = u_sum[17:10];
    assign yuv[CH_V] = v_sum[17:10];

endmodule
`default_nettype wire

// File: tb/tb_subtitle_alpha_blend_yuv_core.sv
// ----------------------------------------------------------------------------
// tb_subtitle_alpha_blend_yuv_core
// Drives pixels into the subtitle blend core and checks every result transfer
// against a local model of the overlay color conversion, the coverage blend,
// frame clipping and chroma coordinates. A directed table covers the register
// extremes and the clipping cases. Random phases with fresh register settings
// follow, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_subtitle_alpha_blend_yuv_core
    import sab_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 212;
    localparam int TAIL_CYCLES     = 8;

    // Indexes outside the register map; writes to them must be ignored
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_5 = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic [COORD_W-1:0]  px;
        logic [COORD_W-1:0]  py;
        logic [SAMPLE_W-1:0] cov;
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
    } pixel_t;

    typedef struct {
        logic [SAMPLE_W-1:0] luma;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic                wr;
    } blend_result_t;

    typedef struct {
        bit                    is_reg;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [COLOR_W-1:0]    reg_val;
        pixel_t                pix;
        bit                    has_want;
        blend_result_t         want;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [COLOR_W-1:0]    cfg_wdata = '0;

    // Register copies, at their reset values
    logic [COLOR_W-1:0] overlay_rgba = 32'd0;
    logic [SIZE_W-1:0]  frame_w      = 14'd1920;
    logic [SIZE_W-1:0]  frame_h      = 14'd1080;
    logic [SHIFT_W-1:0] shift_x      = 2'd1;
    logic [SHIFT_W-1:0] shift_y      = 2'd1;

    blend_result_t blended_q[$];
    stim_row_t     dir_rows[$];
    int            mismatch_count = 0;
    int            cycle_count    = 0;
    int            rx_run         = 0;
    logic          rx_ready       = 1'b0;

    subtitle_alpha_blend_yuv_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic blend_result_t blend_pixel(pixel_t p);
        blend_result_t res;
        int r, g, b, ov_y, ov_u, ov_v, k;
        r = overlay_rgba[31:24];
        g = overlay_rgba[23:16];
        b = overlay_rgba[15:8];
        // signed sums, floor shift
        ov_y = ((263 * r + 516 * g + 100 * b) >>> 10) + 16;
        ov_u = ((450 * b - 152 * r - 298 * g) >>> 10) + 128;
        ov_v = ((450 * r - 376 * g - 73 * b) >>> 10) + 128;
        res.cx = p.px >> shift_x;
        res.cy = p.py >> shift_y;
        if (int'(p.px) < int'(frame_w) && int'(p.py) < int'(frame_h)) begin
            k = (int'(p.cov) * (255 - int'(overlay_rgba[7:0]))) >> 8;
            res.luma = 8'((k * ov_y + (255 - k) * int'(p.luma)) >> 8);
            res.cb   = 8'((k * ov_u + (255 - k) * int'(p.cb)) >> 8);
            res.cr   = 8'((k * ov_v + (255 - k) * int'(p.cr)) >> 8);
            res.wr   = 1'b1;
        end else begin
            res.luma = p.luma;
            res.cb   = p.cb;
            res.cr   = p.cr;
            res.wr   = 1'b0;
        end
        return res;
    endfunction

    function automatic stim_row_t pix_row(int px, int py, int cov, int l, int u, int v);
        stim_row_t row;
        row          = '{default: '0};
        row.pix      = '{px: 13'(px), py: 13'(py), cov: 8'(cov),
                         luma: 8'(l), cb: 8'(u), cr: 8'(v)};
        row.has_want = 1'b0;
        return row;
    endfunction

    // Clipped pixel: samples pass through, only the chroma coordinates move
    function automatic stim_row_t clip_row(int px, int py, int cov, int l, int u, int v,
                                           int cx, int cy);
        stim_row_t row;
        row          = pix_row(px, py, cov, l, u, v);
        row.has_want = 1'b1;
        row.want     = '{luma: 8'(l), cb: 8'(u), cr: 8'(v),
                         cx: 13'(cx), cy: 13'(cy), wr: 1'b0};
        return row;
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] idx, logic [COLOR_W-1:0] val);
        stim_row_t row;
        row         = '{default: '0};
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(int lim);
        int pick, lo, hi;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            hi = (lim > 8191) ? 8191 : lim;
            return 13'($urandom_range(0, hi));
        end else if (pick < 6) begin
            // hug the clipping edge
            lo = (lim < 2) ? 0 : lim - 2;
            hi = (lim + 1 > 8191) ? 8191 : lim + 1;
            if (lo > hi) lo = hi;
            return 13'($urandom_range(lo, hi));
        end
        return 13'($urandom_range(0, 8191));
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 8'd0;
        if (pick == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [COLOR_W-1:0] rand_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 32'd0;
        if (pick == 1) return 32'($urandom_range(8193, 16383));
        if (pick < 6)  return 32'($urandom_range(1, 64));
        return 32'($urandom_range(1, 8192));
    endfunction

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [COLOR_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        case (idx)
            REG_OVERLAY_COLOR:  overlay_rgba = val;
            REG_FRAME_WIDTH:    frame_w      = val[SIZE_W-1:0];
            REG_FRAME_HEIGHT:   frame_h      = val[SIZE_W-1:0];
            REG_CHROMA_SHIFT_X: shift_x      = val[SHIFT_W-1:0];
            REG_CHROMA_SHIFT_Y: shift_y      = val[SHIFT_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic send_pixel(pixel_t p, blend_result_t want);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, p.cr, p.cb, p.luma, p.cov, p.py, p.px};
        do @(posedge aclk); while (!s_tready);
        blended_q.push_back(want);
    endtask

    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
    endtask

    // Drop valid and hold until every pending result has been seen
    task automatic drain_sender();
        sender_gap(1);
        while (blended_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Output side: alternate long open runs, short open runs and stalls
    always @(negedge aclk) begin
        if (rx_run == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    rx_ready = 1'b1;
                    rx_run   = $urandom_range(20, 80);
                end
                3, 4, 5, 6: begin
                    rx_ready = 1'b1;
                    rx_run   = $urandom_range(1, 6);
                end
                default: begin
                    rx_ready = 1'b0;
                    rx_run   = $urandom_range(1, 12);
                end
            endcase
        end
        rx_run--;
        m_tready = rx_ready;
    end

    always @(posedge aclk) begin : result_check
        blend_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (blended_q.size() == 0) begin
                $error("result transfer with no pending pixel");
                mismatch_count++;
            end else begin
                want = blended_q.pop_front();
                check_field("luma_out", want.luma, m_tdata[7:0]);
                check_field("cb_out",   want.cb,   m_tdata[15:8]);
                check_field("cr_out",   want.cr,   m_tdata[23:16]);
                check_field("chroma_x", want.cx,   m_tdata[36:24]);
                check_field("chroma_y", want.cy,   m_tdata[49:37]);
                check_field("written",  want.wr,   m_tuser[0]);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("subtitle_alpha_blend_yuv_core: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        pixel_t p;
        int     burst_left;
        int     gap;

        // Reset defaults first, then color, size and shift extremes
        dir_rows.push_back(pix_row(0, 0, 0, 0, 0, 0));
        dir_rows.push_back(pix_row(1919, 1079, 255, 255, 255, 255));
        dir_rows.push_back(clip_row(1920, 5, 200, 12, 34, 56, 960, 2));
        dir_rows.push_back(clip_row(7, 1080, 200, 90, 80, 70, 3, 540));
        dir_rows.push_back(clip_row(8191, 8191, 255, 255, 255, 255, 4095, 4095));
        dir_rows.push_back(reg_row(REG_OVERLAY_COLOR, 32'hFFFF_FF00));
        dir_rows.push_back(pix_row(100, 200, 255, 0, 0, 0));
        dir_rows.push_back(pix_row(101, 201, 128, 255, 255, 255));
        dir_rows.push_back(reg_row(REG_OVERLAY_COLOR, 32'hFF00_00FF));
        dir_rows.push_back(pix_row(5, 5, 255, 40, 50, 60));
        dir_rows.push_back(reg_row(REG_OVERLAY_COLOR, 32'h00FF_0080));
        dir_rows.push_back(pix_row(6, 9, 200, 128, 128, 128));
        dir_rows.push_back(reg_row(REG_OVERLAY_COLOR, 32'h0000_FF00));
        dir_rows.push_back(pix_row(10, 11, 255, 16, 240, 17));
        dir_rows.push_back(reg_row(REG_FRAME_WIDTH, 32'd0));
        dir_rows.push_back(clip_row(0, 0, 255, 1, 2, 3, 0, 0));
        dir_rows.push_back(reg_row(REG_FRAME_WIDTH, 32'd16383));
        dir_rows.push_back(reg_row(REG_FRAME_HEIGHT, 32'd8192));
        dir_rows.push_back(pix_row(8191, 8191, 255, 200, 100, 50));
        dir_rows.push_back(pix_row(8191, 0, 77, 3, 250, 9));
        dir_rows.push_back(reg_row(REG_FRAME_HEIGHT, 32'd1));
        dir_rows.push_back(clip_row(3, 1, 99, 21, 22, 23, 1, 0));
        dir_rows.push_back(reg_row(REG_CHROMA_SHIFT_X, 32'd3));
        dir_rows.push_back(reg_row(REG_CHROMA_SHIFT_Y, 32'd0));
        dir_rows.push_back(clip_row(8191, 8191, 255, 31, 32, 33, 1023, 8191));
        dir_rows.push_back(reg_row(REG_CHROMA_SHIFT_X, 32'd0));
        dir_rows.push_back(reg_row(REG_CHROMA_SHIFT_Y, 32'd3));
        dir_rows.push_back(reg_row(REG_FRAME_HEIGHT, 32'd8192));
        dir_rows.push_back(pix_row(8191, 8191, 1, 255, 0, 255));
        dir_rows.push_back(reg_row(REG_CHROMA_SHIFT_X, 32'd2));
        dir_rows.push_back(reg_row(REG_CHROMA_SHIFT_Y, 32'd2));
        dir_rows.push_back(pix_row(4097, 6143, 254, 0, 255, 0));
        dir_rows.push_back(reg_row(REG_SPARE_5, 32'd0));
        dir_rows.push_back(reg_row(REG_SPARE_6, 32'd0));
        dir_rows.push_back(reg_row(REG_SPARE_7, 32'hFFFF_FFFF));
        dir_rows.push_back(pix_row(4000, 4000, 180, 60, 70, 80));
        dir_rows.push_back(reg_row(REG_FRAME_WIDTH, 32'd1));
        dir_rows.push_back(reg_row(REG_FRAME_HEIGHT, 32'd1));
        dir_rows.push_back(pix_row(0, 0, 255, 255, 255, 255));
        dir_rows.push_back(clip_row(1, 0, 255, 44, 55, 66, 0, 0));
        dir_rows.push_back(reg_row(REG_FRAME_WIDTH, 32'd8192));
        dir_rows.push_back(pix_row(8191, 0, 255, 0, 0, 0));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                drain_sender();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_pixel(dir_rows[i].pix,
                           dir_rows[i].has_want ? dir_rows[i].want
                                                : blend_pixel(dir_rows[i].pix));
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_sender();
            case ($urandom_range(0, 3))
                0:       cfg_write(REG_OVERLAY_COLOR,
                                   {24'($urandom_range(0, 32'hFFFFFF)), 8'h00});
                1:       cfg_write(REG_OVERLAY_COLOR,
                                   {24'($urandom_range(0, 32'hFFFFFF)), 8'hFF});
                default: cfg_write(REG_OVERLAY_COLOR, $urandom);
            endcase
            cfg_write(REG_FRAME_WIDTH, rand_size());
            cfg_write(REG_FRAME_HEIGHT, rand_size());
            cfg_write(REG_CHROMA_SHIFT_X, 32'($urandom_range(0, 3)));
            cfg_write(REG_CHROMA_SHIFT_Y, 32'($urandom_range(0, 3)));
            if ($urandom_range(0, 2) == 0)
                cfg_write(3'($urandom_range(REG_SPARE_5, REG_SPARE_7)), $urandom);

            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (burst_left == 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    sender_gap(gap);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                             : $urandom_range(1, 12);
                end
                burst_left--;
                p.px   = rand_coord(frame_w);
                p.py   = rand_coord(frame_h);
                p.cov  = rand_sample();
                p.luma = rand_sample();
                p.cb   = rand_sample();
                p.cr   = rand_sample();
                send_pixel(p, blend_pixel(p));
            end
        end

        drain_sender();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && blended_q.size() == 0) begin
            $display("subtitle_alpha_blend_yuv_core: match");
        end else begin
            $display("subtitle_alpha_blend_yuv_core: mismatch");
        end
        $finish;
    end

endmodule
